[hw/rtl/mfd_pkg.sv]
// Package: shared types, codes and default sizes for the message FIFO with drop.
`default_nettype none
package mfd_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned SLOT_BYTES_DEF = 128;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned LENGTH_W = 8;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_POP    = 2'd1,
    MODE_READ   = 2'd2,
    MODE_IDLE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_LONG  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_e status;
  } step_t;

endpackage
`default_nettype wire

[hw/rtl/mfd_if.sv]
// Interfaces: request and result channels of the message FIFO with drop.
`default_nettype none
interface mfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [mfd_pkg::MODE_W-1:0]    mode;
  logic [mfd_pkg::BYTE_W-1:0]    data_byte;
  logic                          end_of_message;
  logic [mfd_pkg::OFFSET_W-1:0]  read_offset;

  modport source (output valid, mode, data_byte, end_of_message, read_offset, input ready);
  modport sink (input valid, mode, data_byte, end_of_message, read_offset, output ready);
endinterface

interface mfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [mfd_pkg::BYTE_W-1:0]    read_byte;
  logic [mfd_pkg::LENGTH_W-1:0]  head_length;
  logic [mfd_pkg::COUNT_W-1:0]   message_count;
  logic [mfd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, read_byte, head_length, message_count, status, input ready);
  modport sink (input valid, read_byte, head_length, message_count, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/mfd_store.sv]
// Message byte store: single-port synchronous RAM with registered read data.
`default_nettype none
module mfd_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            addr_i,
  input  wire logic [mfd_pkg::BYTE_W-1:0]  wdata_i,
  output logic      [mfd_pkg::BYTE_W-1:0]  rdata_o
);

  logic [mfd_pkg::BYTE_W-1:0] mem [Depth];
  logic [mfd_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/mfd_ctrl.sv]
// Queue control: head/tail pointers, slot lengths, count, drop tracking, RAM commands.
`default_nettype none
module mfd_ctrl #(
  parameter int unsigned SlotCount = mfd_pkg::SLOT_COUNT_DEF,
  parameter int unsigned SlotBytes = mfd_pkg::SLOT_BYTES_DEF,
  parameter int unsigned AddrW     = $clog2(SlotCount * SlotBytes)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [mfd_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [mfd_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                          eom_i,
  input  wire logic [mfd_pkg::OFFSET_W-1:0]  read_offset_i,
  output mfd_pkg::step_t                     step_o,
  output logic      [AddrW-1:0]              mem_addr_o,
  output logic      [mfd_pkg::BYTE_W-1:0]    mem_wdata_o,
  output logic      [mfd_pkg::LENGTH_W-1:0]  head_length_o,
  output logic      [mfd_pkg::COUNT_W-1:0]   message_count_o
);

  localparam int unsigned SlotW  = $clog2(SlotCount);
  localparam int unsigned CountW = $clog2(SlotCount + 1);
  localparam int unsigned LenW   = $clog2(SlotBytes + 1);
  localparam int unsigned LastBase = (SlotCount - 1) * SlotBytes;

  logic [SlotW-1:0]  head_idx_q, head_idx_d, tail_idx_q, tail_idx_d;
  logic [AddrW-1:0]  head_base_q, head_base_d, tail_base_q, tail_base_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LenW-1:0]   bytes_q, bytes_d;
  mfd_pkg::status_e  drop_q, drop_d, drop_new;
  logic [LenW-1:0]   len_q [SlotCount];
  logic              len_we;
  mfd_pkg::step_t    step;
  logic [AddrW-1:0]  addr;

  function automatic logic [SlotW-1:0] next_idx(input logic [SlotW-1:0] idx);
    next_idx = (idx == SlotW'(SlotCount - 1)) ? '0 : idx + SlotW'(1);
  endfunction

  function automatic logic [AddrW-1:0] next_base(input logic [AddrW-1:0] base);
    next_base = (base == AddrW'(LastBase)) ? '0 : base + AddrW'(SlotBytes);
  endfunction

  always_comb begin
    head_idx_d  = head_idx_q;
    head_base_d = head_base_q;
    tail_idx_d  = tail_idx_q;
    tail_base_d = tail_base_q;
    count_d     = count_q;
    bytes_d     = bytes_q;
    drop_d      = drop_q;
    drop_new    = drop_q;
    len_we      = 1'b0;
    step        = '{wr_en: 1'b0, rd_en: 1'b0, status: mfd_pkg::ST_OK};
    addr        = tail_base_q + AddrW'(bytes_q);
    if (accept_i) begin
      case (mfd_pkg::mode_e'(mode_i))
        mfd_pkg::MODE_APPEND: begin
          if (drop_q == mfd_pkg::ST_OK && bytes_q == '0 && count_q >= CountW'(SlotCount)) begin
            drop_new = mfd_pkg::ST_FULL;
          end
          if (drop_new == mfd_pkg::ST_OK && bytes_q >= LenW'(SlotBytes)) begin
            drop_new = mfd_pkg::ST_LONG;
          end
          if (drop_new != mfd_pkg::ST_OK) begin
            step.status = drop_new;
            if (eom_i) begin
              drop_d  = mfd_pkg::ST_OK;
              bytes_d = '0;
            end else begin
              drop_d = drop_new;
            end
          end else begin
            step.wr_en = 1'b1;
            bytes_d    = bytes_q + LenW'(1);
            if (eom_i) begin
              len_we      = 1'b1;
              tail_idx_d  = next_idx(tail_idx_q);
              tail_base_d = next_base(tail_base_q);
              count_d     = count_q + CountW'(1);
              bytes_d     = '0;
            end
          end
        end
        mfd_pkg::MODE_POP: begin
          if (count_q == '0) begin
            step.status = mfd_pkg::ST_EMPTY;
          end else begin
            head_idx_d  = next_idx(head_idx_q);
            head_base_d = next_base(head_base_q);
            count_d     = count_q - CountW'(1);
          end
        end
        mfd_pkg::MODE_READ: begin
          addr = head_base_q + AddrW'(read_offset_i);
          if (32'(read_offset_i) < 32'(SlotBytes)) begin
            step.rd_en = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx_q  <= '0;
      head_base_q <= '0;
      tail_idx_q  <= '0;
      tail_base_q <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      drop_q      <= mfd_pkg::ST_OK;
    end else begin
      head_idx_q  <= head_idx_d;
      head_base_q <= head_base_d;
      tail_idx_q  <= tail_idx_d;
      tail_base_q <= tail_base_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      drop_q      <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[tail_idx_q] <= bytes_q + LenW'(1);
    end
  end

  assign step_o          = step;
  assign mem_addr_o      = addr;
  assign mem_wdata_o     = data_byte_i;
  assign head_length_o   = mfd_pkg::LENGTH_W'(len_q[head_idx_q]);
  assign message_count_o = mfd_pkg::COUNT_W'(count_q);

endmodule
`default_nettype wire

[hw/rtl/message_fifo_with_drop_top.sv]
// Top level: message FIFO with drop, request/result channels and result register.
//
// Usage: in_i carries one request per transfer: append a byte (mode 0, the byte
// flagged end_of_message commits the message), pop the head message (mode 1),
// or read one head message byte at read_offset (mode 2). out_o returns exactly
// one result per request, in order: the byte read (zero unless mode 2), the
// stored length of the head slot, the committed message count and a status
// code (ok, dropped on full, dropped too long, pop on empty).
// A result passes the one-entry stage, then the result register, as the byte
// RAM read port is registered. Throughput: one request per cycle unless stalled.
// A request sits in a one-entry stage while the RAM read completes, then moves
// into the result register; when the receiver stalls, the result holds, the
// stage fills, and in_i.ready drops until the result transfers.
// Reset clears pointers, count and drop state; RAM contents and slot lengths
// stay undefined until written. No clearing pass is needed after reset.
`default_nettype none
module message_fifo_with_drop_top #(
  parameter int unsigned SlotCount = mfd_pkg::SLOT_COUNT_DEF,
  parameter int unsigned SlotBytes = mfd_pkg::SLOT_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mfd_in_if.sink    in_i,
  mfd_out_if.source out_o
);

  localparam int unsigned Depth = SlotCount * SlotBytes;
  localparam int unsigned AddrW = $clog2(Depth);

  logic                           accept, advance;
  mfd_pkg::step_t                 step;
  logic [AddrW-1:0]               mem_addr;
  logic [mfd_pkg::BYTE_W-1:0]     mem_wdata, mem_rdata;
  logic [mfd_pkg::LENGTH_W-1:0]   head_length;
  logic [mfd_pkg::COUNT_W-1:0]    message_count;

  logic                           pend_valid_q, pend_valid_d;
  logic                           pend_rd_q;
  mfd_pkg::status_e               pend_status_q;
  logic                           out_valid_q, out_valid_d;
  logic [mfd_pkg::BYTE_W-1:0]     read_byte_q;
  logic [mfd_pkg::LENGTH_W-1:0]   head_length_q;
  logic [mfd_pkg::COUNT_W-1:0]    count_q;
  mfd_pkg::status_e               status_q;

  assign advance    = pend_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  mfd_ctrl #(
    .SlotCount (SlotCount),
    .SlotBytes (SlotBytes),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .mode_i          (in_i.mode),
    .data_byte_i     (in_i.data_byte),
    .eom_i           (in_i.end_of_message),
    .read_offset_i   (in_i.read_offset),
    .step_o          (step),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .head_length_o   (head_length),
    .message_count_o (message_count)
  );

  mfd_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .wr_en_i (step.wr_en),
    .rd_en_i (step.rd_en),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (advance) begin
      pend_valid_d = 1'b0;
    end
    if (accept) begin
      pend_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_rd_q     <= step.rd_en;
      pend_status_q <= step.status;
    end
    if (advance) begin
      read_byte_q   <= pend_rd_q ? mem_rdata : '0;
      head_length_q <= head_length;
      count_q       <= message_count;
      status_q      <= pend_status_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_byte     = read_byte_q;
  assign out_o.head_length   = head_length_q;
  assign out_o.message_count = count_q;
  assign out_o.status        = status_q;

endmodule
`default_nettype wire

[hw/rtl/mfd_checker.sv]
// Checker: port-level assertions for the message FIFO with drop, bound to the top level.
`default_nettype none
module mfd_checker #(
  parameter int unsigned SlotCount = mfd_pkg::SLOT_COUNT_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [mfd_pkg::BYTE_W-1:0]    read_byte_i,
  input wire logic [mfd_pkg::COUNT_W-1:0]   message_count_i,
  input wire logic [mfd_pkg::STATUS_W-1:0]  status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_byte_i)
      && $stable(status_i) && $stable(message_count_i))
    else $error("result dropped or changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(message_count_i) <= SlotCount)
    else $error("message count above slot count");

  a_byte_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != mfd_pkg::ST_OK |-> read_byte_i == '0)
    else $error("nonzero read byte on non-read result");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == mfd_pkg::ST_EMPTY |-> message_count_i == '0)
    else $error("pop on empty reported with messages held");

endmodule

bind message_fifo_with_drop_top mfd_checker #(
  .SlotCount (SlotCount)
) u_mfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .read_byte_i     (out_o.read_byte),
  .message_count_i (out_o.message_count),
  .status_i        (out_o.status)
);
`default_nettype wire
